[rtl/four_sensor_sun_tracker_step_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sun tracker step block
// Shared forms for the concurrent checks at the end of the RTL module.
// ----------------------------------------------------------------------------
`ifndef FOUR_SENSOR_SUN_TRACKER_STEP_TOP_MACROS_SVH
`define FOUR_SENSOR_SUN_TRACKER_STEP_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FSST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fsst_pkg.sv]
// ----------------------------------------------------------------------------
// fsst_pkg
// Types, codes and arithmetic helpers of the sun tracker step block.
// ----------------------------------------------------------------------------
package fsst_pkg;

  localparam int LEVEL_W  = 12;
  localparam int ANGLE_W  = 8;
  localparam int DIVSR_W  = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  // Quotient bits retired per cycle by the serial divider.
  localparam int DIGIT_W  = 2;
  localparam int DIGITS   = LEVEL_W / DIGIT_W;
  localparam int DCNT_W   = $clog2(DIGITS);
  localparam int SUM_W    = LEVEL_W + 2;

  localparam logic [CFG_W-1:0] STANDBY_PAIR_RESET = 16'h5A5A;

  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [ANGLE_W-1:0]   angle_t;
  typedef logic [DIVSR_W-1:0]   divisor_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  typedef logic [DCNT_W-1:0]    digit_cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRACKING_ENABLE      = 3'd0,
    REG_STANDBY_THRESHOLD    = 3'd1,
    REG_CONVERGE_DIVISOR     = 3'd2,
    REG_VERTICAL_MIN_ANGLE   = 3'd3,
    REG_VERTICAL_MAX_ANGLE   = 3'd4,
    REG_HORIZONTAL_MIN_ANGLE = 3'd5,
    REG_HORIZONTAL_MAX_ANGLE = 3'd6,
    REG_STANDBY_ANGLE_PAIR   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_WORKING  = 2'd0,
    MODE_STANDBY  = 2'd1,
    MODE_DISABLED = 2'd2
  } tracker_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_V,
    ST_DIV_H,
    ST_FINISH
  } state_t;

  // One restoring step: returns {quotient bit, new remainder}.
  function automatic logic [DIVSR_W:0] div_step(input divisor_t rem,
                                                input logic     bit_in,
                                                input divisor_t dvs);
    logic [DIVSR_W:0] r;
    r = {rem, bit_in};
    if (r >= {1'b0, dvs}) begin
      div_step = {1'b1, DIVSR_W'(r - {1'b0, dvs})};
    end else begin
      div_step = {1'b0, r[DIVSR_W-1:0]};
    end
  endfunction

  // Add a signed step to an angle, then clamp: low limit wins when crossed.
  function automatic angle_t move_angle(input angle_t angle,
                                        input level_t qmag,
                                        input logic   neg,
                                        input angle_t lo,
                                        input angle_t hi);
    logic signed [SUM_W-1:0] step;
    logic signed [SUM_W-1:0] a;
    step = $signed({2'b00, qmag});
    if (neg) begin
      step = -step;
    end
    a = $signed({{(SUM_W-ANGLE_W){1'b0}}, angle}) + step;
    if (a < $signed({{(SUM_W-ANGLE_W){1'b0}}, lo})) begin
      move_angle = lo;
    end else if (a > $signed({{(SUM_W-ANGLE_W){1'b0}}, hi})) begin
      move_angle = hi;
    end else begin
      move_angle = a[ANGLE_W-1:0];
    end
  endfunction

endpackage

[rtl/fsst_ifs.sv]
// ----------------------------------------------------------------------------
// fsst channel interfaces
// Valid/ready channels for the light readings and the servo commands.
// ----------------------------------------------------------------------------
interface fsst_levels_if;
  logic        valid;
  logic        ready;
  logic [11:0] top_left_level;
  logic [11:0] top_right_level;
  logic [11:0] bottom_left_level;
  logic [11:0] bottom_right_level;

  modport source(output valid, top_left_level, top_right_level,
                 bottom_left_level, bottom_right_level, input ready);
  modport sink(input valid, top_left_level, top_right_level,
               bottom_left_level, bottom_right_level, output ready);
endinterface

interface fsst_command_if;
  logic        valid;
  logic        ready;
  logic [7:0]  vertical_command;
  logic [7:0]  horizontal_command;
  logic [1:0]  tracker_mode;
  logic [11:0] brightness_level;

  modport source(output valid, vertical_command, horizontal_command,
                 tracker_mode, brightness_level, input ready);
  modport sink(input valid, vertical_command, horizontal_command,
               tracker_mode, brightness_level, output ready);
endinterface

[rtl/four_sensor_sun_tracker_step_top.sv]
// One item at a time: after a levels transfer the step runs the vertical and
//   then the horizontal division (when tracking) and loads the output
//   register; when parked or in standby it goes straight to the output load.
//   The shared 2-bit-per-cycle divider runs twice per item; a held command
//   stalls input.
// Reset (rst, synchronous): configuration registers to defaults, kept angles to 90/90.
// ----------------------------------------------------------------------------
// four_sensor_sun_tracker_step_top
// Dual-axis four-sensor sun tracker: pair averages, brightness check and
// clamped angle steps from a serial divider shared by both axes.
// ----------------------------------------------------------------------------
`include "four_sensor_sun_tracker_step_top_macros.svh"

module four_sensor_sun_tracker_step_top #(
  parameter int PARK_VERTICAL_ANGLE   = 90,
  parameter int PARK_HORIZONTAL_ANGLE = 90
) (
  input  logic                  clk,
  input  logic                  rst,
  fsst_levels_if.sink           levels,
  fsst_command_if.source        command,
  input  logic                  cfg_we,
  input  fsst_pkg::cfg_index_t  cfg_index,
  input  fsst_pkg::cfg_data_t   cfg_data
);
  import fsst_pkg::*;

  // configuration registers
  logic          tracking_enable;
  level_t        standby_threshold;
  divisor_t      converge_divisor;
  angle_t        vertical_min_angle;
  angle_t        vertical_max_angle;
  angle_t        horizontal_min_angle;
  angle_t        horizontal_max_angle;
  cfg_data_t     standby_angle_pair;

  // kept state and control
  state_t        st, st_next;
  digit_cnt_t    cnt, cnt_next;
  angle_t        vertical_angle, vertical_angle_next;
  angle_t        horizontal_angle, horizontal_angle_next;
  logic          out_valid, out_valid_next;

  // datapath
  level_t        work, work_next;
  divisor_t      rem, rem_next;
  logic          qneg, qneg_next;
  level_t        hmag, hmag_next;
  logic          hneg, hneg_next;
  level_t        bright, bright_next;
  angle_t        res_v, res_v_next;
  angle_t        res_h, res_h_next;
  tracker_mode_t res_mode, res_mode_next;
  angle_t        out_v, out_v_next;
  angle_t        out_h, out_h_next;
  tracker_mode_t out_mode, out_mode_next;
  level_t        out_bright, out_bright_next;

  // averages of the incoming set
  level_t        avt, avd, avl, avr, bright_in;
  logic          vneg_in, hneg_in;
  level_t        vmag_in, hmag_in;
  divisor_t      dvs;
  logic [DIVSR_W:0] s1, s0;
  level_t        quot;

  always_comb begin
    avt = LEVEL_W'(({1'b0, levels.top_left_level} + {1'b0, levels.top_right_level}) >> 1);
    avd = LEVEL_W'(({1'b0, levels.bottom_left_level}
                    + {1'b0, levels.bottom_right_level}) >> 1);
    avl = LEVEL_W'(({1'b0, levels.top_left_level}
                    + {1'b0, levels.bottom_left_level}) >> 1);
    avr = LEVEL_W'(({1'b0, levels.top_right_level}
                    + {1'b0, levels.bottom_right_level}) >> 1);
    bright_in = LEVEL_W'(({1'b0, avt} + {1'b0, avl}) >> 1);
    vneg_in = avd < avt;
    hneg_in = avr < avl;
    vmag_in = vneg_in ? avt - avd : avd - avt;
    hmag_in = hneg_in ? avl - avr : avr - avl;
  end

  // two restoring steps per cycle, dividend shifted out of the top of work
  always_comb begin
    dvs  = (converge_divisor == '0) ? DIVSR_W'(1) : converge_divisor;
    s1   = div_step(rem, work[LEVEL_W-1], dvs);
    s0   = div_step(s1[DIVSR_W-1:0], work[LEVEL_W-2], dvs);
    quot = {work[LEVEL_W-DIGIT_W-1:0], s1[DIVSR_W], s0[DIVSR_W]};
  end

  always_comb begin
    st_next               = st;
    cnt_next              = cnt;
    vertical_angle_next   = vertical_angle;
    horizontal_angle_next = horizontal_angle;
    out_valid_next        = out_valid;
    work_next             = work;
    rem_next              = rem;
    qneg_next             = qneg;
    hmag_next             = hmag;
    hneg_next             = hneg;
    bright_next           = bright;
    res_v_next            = res_v;
    res_h_next            = res_h;
    res_mode_next         = res_mode;
    out_v_next            = out_v;
    out_h_next            = out_h;
    out_mode_next         = out_mode;
    out_bright_next       = out_bright;
    levels.ready          = 1'b0;

    if (out_valid && command.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (st)
      ST_IDLE: begin
        // no transfer while reset is held
        levels.ready = !rst;
        if (levels.valid) begin
          bright_next = bright_in;
          if (!tracking_enable) begin
            res_v_next    = ANGLE_W'(PARK_VERTICAL_ANGLE);
            res_h_next    = ANGLE_W'(PARK_HORIZONTAL_ANGLE);
            res_mode_next = MODE_DISABLED;
            st_next       = ST_FINISH;
          end else if (bright_in < standby_threshold) begin
            res_v_next    = standby_angle_pair[CFG_W-1:ANGLE_W];
            res_h_next    = standby_angle_pair[ANGLE_W-1:0];
            res_mode_next = MODE_STANDBY;
            st_next       = ST_FINISH;
          end else begin
            res_mode_next = MODE_WORKING;
            work_next     = vmag_in;
            qneg_next     = vneg_in;
            hmag_next     = hmag_in;
            hneg_next     = hneg_in;
            rem_next      = '0;
            cnt_next      = '0;
            st_next       = ST_DIV_V;
          end
        end
      end
      ST_DIV_V: begin
        work_next = quot;
        rem_next  = s0[DIVSR_W-1:0];
        cnt_next  = cnt + 1'b1;
        if (cnt == DCNT_W'(DIGITS - 1)) begin
          vertical_angle_next = move_angle(vertical_angle, quot, qneg,
                                           vertical_min_angle, vertical_max_angle);
          res_v_next = vertical_angle_next;
          work_next  = hmag;
          qneg_next  = hneg;
          rem_next   = '0;
          cnt_next   = '0;
          st_next    = ST_DIV_H;
        end
      end
      ST_DIV_H: begin
        work_next = quot;
        rem_next  = s0[DIVSR_W-1:0];
        cnt_next  = cnt + 1'b1;
        if (cnt == DCNT_W'(DIGITS - 1)) begin
          horizontal_angle_next = move_angle(horizontal_angle, quot, qneg,
                                             horizontal_min_angle,
                                             horizontal_max_angle);
          res_h_next = horizontal_angle_next;
          cnt_next   = '0;
          st_next    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hand over once the output register is free
        if (!out_valid || command.ready) begin
          out_v_next      = res_v;
          out_h_next      = res_h;
          out_mode_next   = res_mode;
          out_bright_next = bright;
          out_valid_next  = 1'b1;
          st_next         = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st               <= ST_IDLE;
      cnt              <= '0;
      out_valid        <= 1'b0;
      vertical_angle   <= STANDBY_PAIR_RESET[CFG_W-1:ANGLE_W];
      horizontal_angle <= STANDBY_PAIR_RESET[ANGLE_W-1:0];
    end else begin
      st               <= st_next;
      cnt              <= cnt_next;
      out_valid        <= out_valid_next;
      vertical_angle   <= vertical_angle_next;
      horizontal_angle <= horizontal_angle_next;
    end
  end

  always_ff @(posedge clk) begin
    work       <= work_next;
    rem        <= rem_next;
    qneg       <= qneg_next;
    hmag       <= hmag_next;
    hneg       <= hneg_next;
    bright     <= bright_next;
    res_v      <= res_v_next;
    res_h      <= res_h_next;
    res_mode   <= res_mode_next;
    out_v      <= out_v_next;
    out_h      <= out_h_next;
    out_mode   <= out_mode_next;
    out_bright <= out_bright_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_enable      <= 1'b1;
      standby_threshold    <= LEVEL_W'(100);
      converge_divisor     <= DIVSR_W'(10);
      vertical_min_angle   <= ANGLE_W'(0);
      vertical_max_angle   <= ANGLE_W'(180);
      horizontal_min_angle <= ANGLE_W'(0);
      horizontal_max_angle <= ANGLE_W'(180);
      standby_angle_pair   <= STANDBY_PAIR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TRACKING_ENABLE:      tracking_enable      <= cfg_data[0];
        REG_STANDBY_THRESHOLD:    standby_threshold    <= cfg_data[LEVEL_W-1:0];
        REG_CONVERGE_DIVISOR:     converge_divisor     <= cfg_data[DIVSR_W-1:0];
        REG_VERTICAL_MIN_ANGLE:   vertical_min_angle   <= cfg_data[ANGLE_W-1:0];
        REG_VERTICAL_MAX_ANGLE:   vertical_max_angle   <= cfg_data[ANGLE_W-1:0];
        REG_HORIZONTAL_MIN_ANGLE: horizontal_min_angle <= cfg_data[ANGLE_W-1:0];
        REG_HORIZONTAL_MAX_ANGLE: horizontal_max_angle <= cfg_data[ANGLE_W-1:0];
        REG_STANDBY_ANGLE_PAIR:   standby_angle_pair   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign command.valid              = out_valid;
  assign command.vertical_command   = out_v;
  assign command.horizontal_command = out_h;
  assign command.tracker_mode       = out_mode;
  assign command.brightness_level   = out_bright;

  `FSST_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, levels.valid && levels.ready,
    st != ST_IDLE, "levels transfer did not start a step")
  `FSST_ASSERT_NOW(a_cnt_idle_zero, clk, rst, st == ST_IDLE || st == ST_FINISH,
    cnt == '0, "divider digit count left nonzero outside division")
  `FSST_ASSERT_NEXT(a_load_from_finish, clk, rst, !out_valid && st != ST_FINISH,
    !out_valid, "command offered without a finished step")
  `FSST_ASSERT_NOW(a_park_mode, clk, rst, out_valid && out_mode == MODE_DISABLED,
    out_v == ANGLE_W'(PARK_VERTICAL_ANGLE) && out_h == ANGLE_W'(PARK_HORIZONTAL_ANGLE),
    "disabled step did not command park angles")

endmodule
